FILE: src/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types and constants for the serial servo bus master.
// ----------------------------------------------------------------------------
package ssb_pkg;

   localparam int unsigned MAX_TARGET_ID = 4;
   localparam int unsigned BODY_MAX      = 10;
   localparam int unsigned QUEUE_DEPTH   = 2;

   // command codes
   localparam logic [2:0] CMD_MOVE     = 3'd0;
   localparam logic [2:0] CMD_READ_POS = 3'd1;
   localparam logic [2:0] CMD_CLR_TURN = 3'd2;
   localparam logic [2:0] CMD_SET_MODE = 3'd3;
   localparam logic [2:0] CMD_SET_SPD  = 3'd4;
   localparam logic [2:0] CMD_RX_BYTE  = 3'd5;
   localparam logic [2:0] CMD_TICK     = 3'd6;

   // result kinds
   localparam logic [1:0] RK_STATUS = 2'd0;
   localparam logic [1:0] RK_TX     = 2'd1;
   localparam logic [1:0] RK_UPDATE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PARAM = 2'd1;
   localparam logic [1:0] ST_BUSY  = 2'd2;

   // frame constants
   localparam logic [7:0] HDR_BYTE     = 8'hFF;
   localparam logic [7:0] INS_READ     = 8'h02;
   localparam logic [7:0] INS_WRITE    = 8'h03;
   localparam logic [7:0] INS_CLR      = 8'h0A;
   localparam logic [7:0] ADDR_GOAL    = 8'h2A;
   localparam logic [7:0] ADDR_PRESENT = 8'h38;
   localparam logic [7:0] ADDR_MODE    = 8'h21;
   localparam logic [7:0] ADDR_SPEED   = 8'h2E;
   localparam logic [7:0] LEN_MOVE     = 8'h09;
   localparam logic [7:0] LEN_READ     = 8'h04;
   localparam logic [7:0] LEN_CLR      = 8'h02;
   localparam logic [7:0] LEN_MODE     = 8'h04;
   localparam logic [7:0] LEN_SPEED    = 8'h05;
   localparam logic [7:0] READ_COUNT   = 8'h02;
   localparam logic [16:0] MAX_WHEEL   = 17'd3400;
   localparam logic [15:0] WHEEL_SIGN  = 16'd32768;
   localparam logic [7:0] TIMEOUT_RST  = 8'd10;

   typedef enum logic [1:0] {
      JOB_STATUS,
      JOB_UPDATE,
      JOB_FRAME
   } job_kind_type;

   // work handed from front to back
   typedef struct packed {
      job_kind_type                 kind;
      logic [1:0]                   status;
      logic [7:0]                   upd_id;
      logic [15:0]                  upd_pos;
      logic [3:0]                   len;
      logic [BODY_MAX-1:0][7:0]     body;
   } job_type;

endpackage

FILE: src/serial_servo_bus_master.sv
// ----------------------------------------------------------------------------
// serial_servo_bus_master
// Master side of a half-duplex servo bus: frame builder and reply parser.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a transaction is taken when push is high
// and full is low. Commands 0..4 build a checksummed frame (or a status-only
// result on a parameter error or busy bus), 5 feeds one received byte to the
// reply parser, 6 is a timeout tick. Result side is a queue read port: the
// oldest result sits on the rsp_ ports while empty is low and leaves when pop
// is high. Each input gives one result, or n+3 transmit results for a frame
// with n body bytes (up to 13 for a move); the last one has last_of_run set.
// The front end takes one transaction per cycle while full is low into a
// two-entry job queue; the back end emits one result per cycle while pop keeps
// its output register free. The first result reaches the rsp_ ports via the job
// queue and the output register. When pop is held low the output register and
// queue fill and full rises. Reset empties the queue, clears the parser and
// sets the reply timeout register to 10 ticks; csr_wr_en writes it. The user must
// write it only while the block is idle; the block itself lacks a check for it.
// ----------------------------------------------------------------------------
module serial_servo_bus_master
   import ssb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               push,
   output logic               full,
   input  logic [2:0]         req_command,
   input  logic [7:0]         req_target_id,
   input  logic [15:0]        req_goal_position,
   input  logic [15:0]        req_run_time,
   input  logic signed [16:0] req_speed_value,
   input  logic [7:0]         req_mode_value,
   input  logic [7:0]         req_rx_byte,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_result_kind,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last_of_run,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_update_id,
   output logic [15:0]        rsp_update_position
);

   job_type fe_job;
   job_type q_job;
   logic    q_full, q_valid, q_pop;
   logic    accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   ssb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .accept        (accept),
      .command       (req_command),
      .target_id     (req_target_id),
      .goal_position (req_goal_position),
      .run_time      (req_run_time),
      .speed_value   (req_speed_value),
      .mode_value    (req_mode_value),
      .rx_byte       (req_rx_byte),
      .job           (fe_job)
   );

   ssb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_data  (fe_job),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_job)
   );

   ssb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_job           (q_job),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .result_kind     (rsp_result_kind),
      .tx_byte         (rsp_tx_byte),
      .last_of_run     (rsp_last_of_run),
      .status          (rsp_status),
      .update_id       (rsp_update_id),
      .update_position (rsp_update_position)
   );

   // status is only carried on the closing result of a transaction
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_last_of_run) |-> (rsp_status == ST_OK))
      else $error("status set on a non-final result");

   // status-only and position-update results always close their transaction
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && ((rsp_result_kind == RK_STATUS) || (rsp_result_kind == RK_UPDATE)))
      |-> rsp_last_of_run)
      else $error("single result without last_of_run");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result present after reset");

   // an update never carries a parameter or busy status
   a_update_ok: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_kind == RK_UPDATE)) |-> (rsp_status == ST_OK))
      else $error("position update with error status");

endmodule

FILE: src/ssb_queue.sv
// ----------------------------------------------------------------------------
// ssb_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module ssb_queue
   import ssb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    rd_valid,
   output job_type rd_data
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);

   job_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            do_wr, do_rd;

   assign full     = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + (PW+1)'(1);
         2'b01:   count_in = count_ff - (PW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/ssb_front.sv
// ----------------------------------------------------------------------------
// ssb_front
// Accepts commands, checks operands, tracks the bus and reply parser,
// and turns each transaction into one job for the back end.
// ----------------------------------------------------------------------------
module ssb_front
   import ssb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               accept,
   input  logic [2:0]         command,
   input  logic [7:0]         target_id,
   input  logic [15:0]        goal_position,
   input  logic [15:0]        run_time,
   input  logic signed [16:0] speed_value,
   input  logic [7:0]         mode_value,
   input  logic [7:0]         rx_byte,
   output job_type            job
);

   logic [7:0] timeout_cfg_ff;
   logic       awaiting_ff, awaiting_in;
   logic [7:0] timeout_left_ff, timeout_left_in;
   logic [3:0] rx_pos_ff, rx_pos_in;
   logic [7:0] prev_byte_ff;
   logic [7:0] reply_ff [2:6];

   logic        id_ok, reply_id_ok;
   logic [16:0] spd_u, mag;
   logic        neg, speed_bad;
   logic [15:0] wheel;
   logic [3:0]  pos_eff;
   logic [7:0]  reply_sum;
   logic        rb_wr;

   assign id_ok = (target_id >= 8'd1) && (target_id <= 8'(MAX_TARGET_ID));
   assign spd_u = speed_value;
   assign neg   = speed_value[16];
   assign mag   = neg ? (~spd_u + 17'd1) : spd_u;
   assign speed_bad = (mag > MAX_WHEEL);
   assign wheel = neg ? (mag[15:0] + WHEEL_SIGN) : mag[15:0];

   // repeated header while deep in a reply restarts the parser
   assign pos_eff = ((prev_byte_ff == HDR_BYTE) && (rx_byte == HDR_BYTE) && (rx_pos_ff > 4'd1))
                    ? 4'd1 : rx_pos_ff;

   assign reply_sum   = reply_ff[2] + reply_ff[3] + reply_ff[4] + reply_ff[5] + reply_ff[6];
   assign reply_id_ok = (reply_ff[2] >= 8'd1) && (reply_ff[2] <= 8'(MAX_TARGET_ID));

   always_comb begin
      awaiting_in     = awaiting_ff;
      timeout_left_in = timeout_left_ff;
      rx_pos_in       = rx_pos_ff;
      rb_wr           = 1'b0;
      job             = '0;
      job.kind        = JOB_STATUS;
      job.status      = ST_OK;

      case (command)
         CMD_RX_BYTE: begin
            rx_pos_in = pos_eff;
            if (awaiting_ff) begin
               if (pos_eff > 4'd7) begin
                  rx_pos_in   = 4'd0;
                  awaiting_in = 1'b0;
               end else if (pos_eff < 4'd2) begin
                  if (rx_byte == HDR_BYTE) begin
                     rx_pos_in = pos_eff + 4'd1;
                  end else begin
                     if (pos_eff == 4'd1) begin
                        awaiting_in = 1'b0;
                     end
                     rx_pos_in = 4'd0;
                  end
               end else if (pos_eff < 4'd7) begin
                  rb_wr     = 1'b1;
                  rx_pos_in = pos_eff + 4'd1;
               end else begin
                  rx_pos_in       = 4'd0;
                  awaiting_in     = 1'b0;
                  timeout_left_in = 8'd0;
                  if ((rx_byte == ~reply_sum) && reply_id_ok) begin
                     job.kind    = JOB_UPDATE;
                     job.upd_id  = reply_ff[2];
                     job.upd_pos = {reply_ff[6], reply_ff[5]};
                  end
               end
            end
         end
         CMD_TICK: begin
            if (awaiting_ff && (timeout_left_ff != 8'd0)) begin
               timeout_left_in = timeout_left_ff - 8'd1;
               if (timeout_left_ff == 8'd1) begin
                  rx_pos_in   = 4'd0;
                  awaiting_in = 1'b0;
               end
            end
         end
         CMD_MOVE, CMD_READ_POS, CMD_CLR_TURN, CMD_SET_MODE, CMD_SET_SPD: begin
            job.body[0] = target_id;
            if (!id_ok) begin
               job.status = ST_PARAM;
            end else if ((command == CMD_SET_MODE) && (mode_value > 8'd3)) begin
               job.status = ST_PARAM;
            end else if ((command == CMD_SET_SPD) && speed_bad) begin
               job.status = ST_PARAM;
            end else if (awaiting_ff) begin
               job.status = ST_BUSY;
            end else begin
               job.kind = JOB_FRAME;
               case (command)
                  CMD_MOVE: begin
                     job.len     = 4'd10;
                     job.body[1] = LEN_MOVE;
                     job.body[2] = INS_WRITE;
                     job.body[3] = ADDR_GOAL;
                     job.body[4] = goal_position[7:0];
                     job.body[5] = goal_position[15:8];
                     job.body[6] = run_time[7:0];
                     job.body[7] = run_time[15:8];
                     job.body[8] = spd_u[7:0];
                     job.body[9] = spd_u[15:8];
                  end
                  CMD_READ_POS: begin
                     awaiting_in     = 1'b1;
                     timeout_left_in = timeout_cfg_ff;
                     job.len         = 4'd5;
                     job.body[1]     = LEN_READ;
                     job.body[2]     = INS_READ;
                     job.body[3]     = ADDR_PRESENT;
                     job.body[4]     = READ_COUNT;
                  end
                  CMD_CLR_TURN: begin
                     job.len     = 4'd3;
                     job.body[1] = LEN_CLR;
                     job.body[2] = INS_CLR;
                  end
                  CMD_SET_MODE: begin
                     job.len     = 4'd5;
                     job.body[1] = LEN_MODE;
                     job.body[2] = INS_WRITE;
                     job.body[3] = ADDR_MODE;
                     job.body[4] = mode_value;
                  end
                  default: begin
                     job.len     = 4'd6;
                     job.body[1] = LEN_SPEED;
                     job.body[2] = INS_WRITE;
                     job.body[3] = ADDR_SPEED;
                     job.body[4] = wheel[7:0];
                     job.body[5] = wheel[15:8];
                  end
               endcase
            end
         end
         default: begin
            job.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_cfg_ff  <= TIMEOUT_RST;
         awaiting_ff     <= 1'b0;
         timeout_left_ff <= 8'd0;
         rx_pos_ff       <= 4'd0;
         prev_byte_ff    <= 8'd0;
      end else begin
         if (csr_wr_en) begin
            timeout_cfg_ff <= csr_wr_data;
         end
         if (accept) begin
            awaiting_ff     <= awaiting_in;
            timeout_left_ff <= timeout_left_in;
            rx_pos_ff       <= rx_pos_in;
            if (command == CMD_RX_BYTE) begin
               prev_byte_ff <= rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 2; i <= 6; i++) begin
         if (accept && rb_wr && (pos_eff == 4'(i))) begin
            reply_ff[i] <= rx_byte;
         end
      end
   end

endmodule

FILE: src/ssb_back.sv
// ----------------------------------------------------------------------------
// ssb_back
// Expands queued jobs into results, one per cycle while the output register is
// free or popped, with the frame checksum accumulated as body bytes go out.
// ----------------------------------------------------------------------------
module ssb_back
   import ssb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  job_type     q_job,
   output logic        q_pop,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  result_kind,
   output logic [7:0]  tx_byte,
   output logic        last_of_run,
   output logic [1:0]  status,
   output logic [7:0]  update_id,
   output logic [15:0] update_position
);

   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  tx_ff;
   logic        last_ff;
   logic [1:0]  status_ff;
   logic [7:0]  upd_id_ff;
   logic [15:0] upd_pos_ff;

   logic        load;
   logic [1:0]  r_kind;
   logic [7:0]  r_tx;
   logic        r_last;
   logic [1:0]  r_status;
   logic [7:0]  r_id;
   logic [15:0] r_pos;
   logic [3:0]  body_idx;
   logic        body_byte;

   assign load     = q_valid && (!out_valid_ff || pop);
   assign body_idx = idx_ff - 4'd2;

   always_comb begin
      r_kind    = RK_STATUS;
      r_tx      = 8'd0;
      r_last    = 1'b1;
      r_status  = ST_OK;
      r_id      = 8'd0;
      r_pos     = 16'd0;
      body_byte = 1'b0;
      unique case (q_job.kind)
         JOB_STATUS: begin
            r_status = q_job.status;
         end
         JOB_UPDATE: begin
            r_kind = RK_UPDATE;
            r_id   = q_job.upd_id;
            r_pos  = q_job.upd_pos;
         end
         JOB_FRAME: begin
            r_kind = RK_TX;
            r_last = 1'b0;
            if (idx_ff < 4'd2) begin
               r_tx = HDR_BYTE;
            end else if (idx_ff == (q_job.len + 4'd2)) begin
               r_tx   = ~sum_ff;
               r_last = 1'b1;
            end else begin
               r_tx      = q_job.body[body_idx];
               body_byte = 1'b1;
            end
         end
         default: begin
            r_status = ST_OK;
         end
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && !pop;
      q_pop        = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         if (r_last) begin
            idx_in = 4'd0;
            sum_in = 8'd0;
            q_pop  = 1'b1;
         end else begin
            idx_in = idx_ff + 4'd1;
            if (body_byte) begin
               sum_in = sum_ff + r_tx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         sum_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= r_kind;
         tx_ff      <= r_tx;
         last_ff    <= r_last;
         status_ff  <= r_status;
         upd_id_ff  <= r_id;
         upd_pos_ff <= r_pos;
      end
   end

   assign empty           = !out_valid_ff;
   assign result_kind     = kind_ff;
   assign tx_byte         = tx_ff;
   assign last_of_run     = last_ff;
   assign status          = status_ff;
   assign update_id       = upd_id_ff;
   assign update_position = upd_pos_ff;

endmodule
